FILE: sv/arm_pkg.sv
// Shared types and constants for the latitude/longitude rotation matrix core.
// No dependencies; imported by arm_lane, arm_merge and the top level.
package arm_pkg;

    // Quarter wave angle scale: pi/2 in Q30 radians.
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;

    // Number of series update steps; cosine uses all of them, sine one fewer.
    localparam int NSTEP = 7;

    // Divisors n(n+1) of the cosine and sine term recurrences, one per step.
    localparam int COS_DIV [NSTEP]   = '{2, 12, 30, 56, 90, 132, 182};
    localparam int SIN_DIV [NSTEP-1] = '{6, 20, 42, 72, 110, 156};

    // Pipeline depths: three setup stages, three per step, one output map.
    localparam int LANE_LAT  = 3 + 3 * NSTEP + 1;
    localparam int MERGE_LAT = 2;
    localparam int TOT_LAT   = LANE_LAT + MERGE_LAT;

    localparam int IN_W  = 32;
    localparam int OUT_W = 128;

    // Running state of one series evaluation between steps.
    typedef struct packed {
        logic        [30:0] ct;
        logic        [30:0] st;
        logic signed [33:0] csum;
        logic signed [33:0] ssum;
        logic        [31:0] x2;
    } term_t;

endpackage

FILE: sv/arm_lane.sv
// One sine/cosine lane: quarter-wave Taylor series evaluated over a pipeline.
// Depends on arm_pkg for the series divisors and the term_t bundle.
module arm_lane (
    input  logic               aclk,
    input  logic               en,
    input  logic        [15:0] phase,
    output logic signed [15:0] sin_o,
    output logic signed [15:0] cos_o
);
    import arm_pkg::*;

    logic [1:0]  quad_reg [LANE_LAT-1];
    logic [30:0] x_reg;
    logic [30:0] xd_reg;
    logic [61:0] sq_reg;
    term_t       bnd [NSTEP+1];
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    // Quadrant travels alongside the series evaluation.
    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[0] <= phase[15:14];
            for (int k = 1; k < LANE_LAT - 1; k++) begin
                quad_reg[k] <= quad_reg[k-1];
            end
        end
    end

    // Scale the reduced phase to radians, square it, and seed the series.
    // The scaled angle is delayed one stage so it lines up with its square.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= 31'(((45'(phase[13:0]) * 45'(HALF_PI_Q30)) + 45'd8192) >> 14);
            sq_reg <= 62'(x_reg) * 62'(x_reg);
            xd_reg <= x_reg;
            bnd[0].x2   <= 32'((sq_reg + 62'(64'd1 << 29)) >> 30);
            bnd[0].ct   <= ONE_Q30;
            bnd[0].st   <= xd_reg;
            bnd[0].csum <= 34'(ONE_Q30);
            bnd[0].ssum <= 34'(xd_reg);
        end
    end

    // Each step: multiply by x^2, divide by a constant, add with alternating sign.
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        localparam int          DC  = COS_DIV[i];
        localparam int          KC  = 32 + $clog2(DC + 1) - 1;
        localparam logic [63:0] MC  = (64'd1 << KC) / DC;
        localparam bit          NEG = (i % 2) == 0;

        term_t       a_reg, b_reg;
        logic [62:0] pc_reg, ps_reg;
        logic [32:0] yc_reg, ys_reg;
        logic [65:0] mc_reg, ms_reg;
        logic [32:0] qc0, qc;
        logic [33:0] rc;
        logic [30:0] st_new;
        logic signed [33:0] ssum_new;

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg  <= bnd[i];
                pc_reg <= 63'(bnd[i].ct) * 63'(bnd[i].x2);
                ps_reg <= 63'(bnd[i].st) * 63'(bnd[i].x2);
                b_reg  <= a_reg;
                yc_reg <= 33'(pc_reg >> 30);
                ys_reg <= 33'(ps_reg >> 30);
                mc_reg <= 66'(33'(pc_reg >> 30)) * 66'(MC[32:0]);
            end
        end

        // Reciprocal quotient can be one short; one compare fixes it.
        always_comb begin
            qc0 = 33'(mc_reg >> KC);
            rc  = {1'b0, yc_reg} - 34'(34'(qc0) * 34'(DC));
            qc  = (rc >= 34'(DC)) ? qc0 + 33'd1 : qc0;
        end

        if (i < NSTEP - 1) begin : g_sin
            localparam int          DS = SIN_DIV[i];
            localparam int          KS = 32 + $clog2(DS + 1) - 1;
            localparam logic [63:0] MS = (64'd1 << KS) / DS;

            logic [32:0] qs0, qs;
            logic [33:0] rs;

            always_ff @(posedge aclk) begin
                if (en) begin
                    ms_reg <= 66'(33'(ps_reg >> 30)) * 66'(MS[32:0]);
                end
            end

            always_comb begin
                qs0      = 33'(ms_reg >> KS);
                rs       = {1'b0, ys_reg} - 34'(34'(qs0) * 34'(DS));
                qs       = (rs >= 34'(DS)) ? qs0 + 33'd1 : qs0;
                st_new   = qs[30:0];
                ssum_new = NEG ? b_reg.ssum - 34'(qs) : b_reg.ssum + 34'(qs);
            end
        end else begin : g_sin_done
            // The sine series is already complete; hold its state.
            always_ff @(posedge aclk) begin
                if (en) begin
                    ms_reg <= 66'(ys_reg);
                end
            end

            always_comb begin
                st_new   = b_reg.st ^ 31'(ms_reg & 66'd0);
                ssum_new = b_reg.ssum;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                bnd[i+1].x2   <= b_reg.x2;
                bnd[i+1].ct   <= qc[30:0];
                bnd[i+1].st   <= st_new;
                bnd[i+1].csum <= NEG ? b_reg.csum - 34'(qc) : b_reg.csum + 34'(qc);
                bnd[i+1].ssum <= ssum_new;
            end
        end
    end

    // Clamp to 0..1, round to Q14 and unfold the quadrant.
    logic [30:0]        s_cl, c_cl;
    logic signed [15:0] s14, c14;

    always_comb begin
        if (bnd[NSTEP].ssum < 0) begin
            s_cl = '0;
        end else if (bnd[NSTEP].ssum > 34'(ONE_Q30)) begin
            s_cl = ONE_Q30;
        end else begin
            s_cl = bnd[NSTEP].ssum[30:0];
        end
        if (bnd[NSTEP].csum < 0) begin
            c_cl = '0;
        end else if (bnd[NSTEP].csum > 34'(ONE_Q30)) begin
            c_cl = ONE_Q30;
        end else begin
            c_cl = bnd[NSTEP].csum[30:0];
        end
        s14 = 16'(((32'(s_cl) + 32'd32768) >> 16));
        c14 = 16'(((32'(c_cl) + 32'd32768) >> 16));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (quad_reg[LANE_LAT-2])
                2'd0: begin
                    sin_reg <= s14;
                    cos_reg <= c14;
                end
                2'd1: begin
                    sin_reg <= c14;
                    cos_reg <= -s14;
                end
                2'd2: begin
                    sin_reg <= -s14;
                    cos_reg <= -c14;
                end
                default: begin
                    sin_reg <= -c14;
                    cos_reg <= s14;
                end
            endcase
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

FILE: sv/arm_merge.sv
// Merging stage: forms the four rounded cross products and packs the result.
// Depends on arm_pkg for the result width.
module arm_merge (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [15:0]     sin_b,
    input  logic signed [15:0]     cos_b,
    input  logic signed [15:0]     sin_l,
    input  logic signed [15:0]     cos_l,
    output logic [arm_pkg::OUT_W-1:0] data_o
);
    import arm_pkg::*;

    logic signed [31:0] p_reg [4];
    logic signed [15:0] v_reg [4];
    logic [OUT_W-1:0]   data_reg;
    logic signed [31:0] rnd [4];

    // Products, registered before rounding.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= cos_b * cos_l;
            p_reg[1] <= cos_b * sin_l;
            p_reg[2] <= sin_b * cos_l;
            p_reg[3] <= sin_b * sin_l;
            v_reg[0] <= sin_b;
            v_reg[1] <= cos_b;
            v_reg[2] <= sin_l;
            v_reg[3] <= cos_l;
        end
    end

    // Round to nearest, halves upward.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (p_reg[k] + 32'sd8192) >>> 14;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {v_reg[3], v_reg[2], v_reg[1], v_reg[0],
                         rnd[3][15:0], rnd[2][15:0], rnd[1][15:0], rnd[0][15:0]};
        end
    end

    assign data_o = data_reg;

endmodule

FILE: sv/angle_rotation_matrix_with_derivs_core.sv
// Top level of the latitude/longitude rotation matrix core.
// Depends on arm_pkg, arm_lane and arm_merge.
//
// Takes one beat of two binary angles (beta, lambda) and returns one beat of
// the eight distinct Q2.14 entries of the rotation matrix and its derivatives.
// Two sine/cosine lanes run side by side and a merging stage forms the cross
// products. One beat is accepted every cycle while the skid entry is empty;
// a result passes through 25 lane stages (three setup stages, seven
// three-stage series steps and the quadrant map), then two merge stages and
// the output register. A two-entry output buffer lets the pipeline run on
// for a beat when the consumer stalls.
module angle_rotation_matrix_with_derivs_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // beta_angle [15:0], lambda_angle [31:16]
    input  logic [arm_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // cb_cl, cb_sl, sb_cl, sb_sl, sin_b, cos_b, sin_l, cos_l, 16 bits each
    output logic [arm_pkg::OUT_W-1:0] m_tdata
);
    import arm_pkg::*;

    logic               en;
    logic [TOT_LAT-1:0] vld_reg;
    logic signed [15:0] sb, cb, sl, cl;
    logic [OUT_W-1:0]   pipe_data;
    logic               out_v_reg, skid_v_reg;
    logic [OUT_W-1:0]   out_d_reg, skid_d_reg;
    logic               pipe_v;

    assign en       = ~skid_v_reg;
    assign s_tready = en;
    assign pipe_v   = vld_reg[TOT_LAT-1] & en;

    arm_lane u_lane_b (
        .aclk  (aclk),
        .en    (en),
        .phase (s_tdata[15:0]),
        .sin_o (sb),
        .cos_o (cb)
    );

    arm_lane u_lane_l (
        .aclk  (aclk),
        .en    (en),
        .phase (s_tdata[31:16]),
        .sin_o (sl),
        .cos_o (cl)
    );

    arm_merge u_merge (
        .aclk   (aclk),
        .en     (en),
        .sin_b  (sb),
        .cos_b  (cb),
        .sin_l  (sl),
        .cos_l  (cl),
        .data_o (pipe_data)
    );

    // Valid bits follow the payload down the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOT_LAT-2:0], s_tvalid};
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_tready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= pipe_v;
            end
        end else if (pipe_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            out_d_reg <= skid_v_reg ? skid_d_reg : pipe_data;
        end else if (pipe_v) begin
            skid_d_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

endmodule
